/* rtl/core/gha_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gha_pkg
// Shared constants, codes and types of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Table geometry
  localparam int SLOTS        = 1024;
  localparam int IDX_W        = 10;                    // slot index field width
  localparam int CNT_W        = $clog2(SLOTS + 1);     // counts 0..SLOTS
  localparam int SERIAL_BITS  = 16;
  localparam int FIRST_SERIAL = 1;

  // Request modes
  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CHECK  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Access bundle for the serial table and the free stack
  typedef struct packed {
    logic [IDX_W-1:0]       ser_rd_addr;
    logic                   ser_we;
    logic [IDX_W-1:0]       ser_wr_addr;
    logic [SERIAL_BITS-1:0] ser_wr_data;
    logic [IDX_W-1:0]       stk_rd_addr;
    logic                   stk_we;
    logic [IDX_W-1:0]       stk_wr_addr;
    logic [IDX_W-1:0]       stk_wr_data;
  } mem_req_t;

endpackage : gha_pkg
`default_nettype wire

/* rtl/core/gha_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gha_req_if / gha_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface gha_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [gha_pkg::IDX_W-1:0]     slot_index;
  logic [gha_pkg::SERIAL_BITS-1:0] generation;

  modport source (output valid, mode, slot_index, generation, input ready);
  modport sink   (input valid, mode, slot_index, generation, output ready);
endinterface : gha_req_if

interface gha_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::IDX_W-1:0]     handle_index;
  logic [gha_pkg::SERIAL_BITS-1:0] handle_serial;
  logic [1:0]                    status;

  modport source (output valid, handle_index, handle_serial, status, input ready);
  modport sink   (input valid, handle_index, handle_serial, status, output ready);
endinterface : gha_rsp_if
`default_nettype wire

/* rtl/core/gha_tables.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gha_tables
// Serial table and free stack: one write and one registered read per cycle
// on each memory.
// ----------------------------------------------------------------------------
module gha_tables (
  input  wire logic                            clk,
  input  wire gha_pkg::mem_req_t               req,
  output logic [gha_pkg::SERIAL_BITS-1:0]      ser_rdata,
  output logic [gha_pkg::IDX_W-1:0]            stk_rdata
);

  logic [gha_pkg::SERIAL_BITS-1:0] serial_mem [gha_pkg::SLOTS];
  logic [gha_pkg::IDX_W-1:0]       stack_mem  [gha_pkg::SLOTS];

  // Serial table
  always_ff @(posedge clk) begin
    if (req.ser_we) begin
      serial_mem[req.ser_wr_addr] <= req.ser_wr_data;
    end
    ser_rdata <= serial_mem[req.ser_rd_addr];
  end

  // Free stack
  always_ff @(posedge clk) begin
    if (req.stk_we) begin
      stack_mem[req.stk_wr_addr] <= req.stk_wr_data;
    end
    stk_rdata <= stack_mem[req.stk_rd_addr];
  end

endmodule : gha_tables
`default_nettype wire

/* rtl/core/generational_handle_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Slot allocator that issues (index, serial) handles with LIFO index reuse.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : one request per transfer (mode, slot_index, generation).
//             mode create returns a fresh handle, remove retires a handle
//             and frees its index, check validates a handle.
//   out_rsp : exactly one result per request, in request order:
//             handle_index, handle_serial and status (ok, full, invalid).
// Timing:
//   A request is taken only while the sequencer is idle. Its tables are read
//   at the transfer edge and decided in the next cycle; a create that reuses
//   a freed index takes one more serial-table read, then the result moves
//   into the output register.
//   A new request is taken only after the previous result has moved into the
//   output register, so the sequencer holds one request at a time; its pace
//   is set by the registered reads of the serial table and free stack and
//   the dependent serial read on reuse.
// Reset:
//   Synchronous, active low. Free count and used count go to zero; table
//   contents need no clearing since only written entries are ever read.
// Stall:
//   A finished result waits in the output register while out_rsp.ready is
//   low; a new request is already accepted in the meantime, and its result
//   waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gha_req_if.sink     in_req,
  gha_rsp_if.source   out_rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [gha_pkg::CNT_W-1:0] SLOTS_C = gha_pkg::CNT_W'(gha_pkg::SLOTS);

  logic [1:0]                        state_r, state_nxt;
  logic [1:0]                        mode_r;
  logic [gha_pkg::IDX_W-1:0]         idx_r;
  logic [gha_pkg::SERIAL_BITS-1:0]   ser_r;
  logic [gha_pkg::CNT_W-1:0]         free_count_r, free_count_nxt;
  logic [gha_pkg::CNT_W-1:0]         used_slots_r, used_slots_nxt;
  logic [gha_pkg::IDX_W-1:0]         res_idx_r, res_idx_nxt;
  logic [gha_pkg::SERIAL_BITS-1:0]   res_ser_r, res_ser_nxt;
  logic [1:0]                        res_status_r, res_status_nxt;
  logic                              out_valid_r;
  logic [gha_pkg::IDX_W-1:0]         out_idx_r;
  logic [gha_pkg::SERIAL_BITS-1:0]   out_ser_r;
  logic [1:0]                        out_status_r;

  gha_pkg::mem_req_t                 mem_req;
  logic [gha_pkg::SERIAL_BITS-1:0]   ser_q;
  logic [gha_pkg::IDX_W-1:0]         stk_q;

  logic in_xfer;
  logic out_free;
  logic handle_ok;
  logic remove_ok;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_xfer      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  // Handle check against the serial read for idx_r
  assign handle_ok = ({1'b0, idx_r} < used_slots_r) && (ser_q == ser_r);
  assign remove_ok = handle_ok && (free_count_r < SLOTS_C);

  gha_tables u_tables (
    .clk       (clk),
    .req       (mem_req),
    .ser_rdata (ser_q),
    .stk_rdata (stk_q)
  );

  // Sequencer: read, decide, write back
  always_comb begin
    state_nxt      = state_r;
    free_count_nxt = free_count_r;
    used_slots_nxt = used_slots_r;
    res_idx_nxt    = res_idx_r;
    res_ser_nxt    = res_ser_r;
    res_status_nxt = res_status_r;

    mem_req             = '0;
    mem_req.ser_rd_addr = in_req.slot_index;
    mem_req.stk_rd_addr = gha_pkg::IDX_W'(free_count_r - 1'b1);
    mem_req.ser_wr_addr = idx_r;
    mem_req.ser_wr_data = gha_pkg::SERIAL_BITS'(ser_q + 1'b1);
    mem_req.stk_wr_addr = gha_pkg::IDX_W'(free_count_r);
    mem_req.stk_wr_data = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // default result echoes the request
        res_idx_nxt    = idx_r;
        res_ser_nxt    = ser_r;
        res_status_nxt = gha_pkg::ST_INVALID;
        state_nxt      = S_OUT;
        mem_req.ser_rd_addr = stk_q;
        unique case (mode_r)
          gha_pkg::MODE_CREATE: begin
            if (free_count_r != '0) begin
              // reuse top of free stack; its serial is read next cycle
              free_count_nxt = free_count_r - 1'b1;
              res_idx_nxt    = stk_q;
              res_status_nxt = gha_pkg::ST_OK;
              state_nxt      = S_POP;
            end else if (used_slots_r < SLOTS_C) begin
              mem_req.ser_we      = 1'b1;
              mem_req.ser_wr_addr = gha_pkg::IDX_W'(used_slots_r);
              mem_req.ser_wr_data = gha_pkg::SERIAL_BITS'(gha_pkg::FIRST_SERIAL);
              used_slots_nxt      = used_slots_r + 1'b1;
              res_idx_nxt         = gha_pkg::IDX_W'(used_slots_r);
              res_ser_nxt         = gha_pkg::SERIAL_BITS'(gha_pkg::FIRST_SERIAL);
              res_status_nxt      = gha_pkg::ST_OK;
            end else begin
              res_status_nxt = gha_pkg::ST_FULL;
            end
          end
          gha_pkg::MODE_REMOVE: begin
            if (remove_ok) begin
              mem_req.ser_we = 1'b1;
              mem_req.stk_we = 1'b1;
              free_count_nxt = free_count_r + 1'b1;
              res_status_nxt = gha_pkg::ST_OK;
            end
          end
          gha_pkg::MODE_CHECK: begin
            res_status_nxt = handle_ok ? gha_pkg::ST_OK : gha_pkg::ST_INVALID;
          end
          default: begin
            res_status_nxt = gha_pkg::ST_INVALID;
          end
        endcase
      end
      S_POP: begin
        res_ser_nxt = ser_q;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_count_r <= '0;
      used_slots_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_count_r <= free_count_nxt;
      used_slots_r <= used_slots_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture, result and output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= in_req.mode;
      idx_r  <= in_req.slot_index;
      ser_r  <= in_req.generation;
    end
    res_idx_r    <= res_idx_nxt;
    res_ser_r    <= res_ser_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == S_OUT && out_free) begin
      out_idx_r    <= res_idx_r;
      out_ser_r    <= res_ser_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.handle_index  = out_idx_r;
  assign out_rsp.handle_serial = out_ser_r;
  assign out_rsp.status        = out_status_r;

  // Checks
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= SLOTS_C)
    else $error("free count exceeds table size");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_slots_r <= SLOTS_C)
    else $error("used slot count exceeds table size");

  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && mode_r == gha_pkg::MODE_REMOVE && remove_ok) |=>
      (free_count_r == $past(free_count_r) + 1'b1))
    else $error("accepted remove did not push free stack");

  a_pop_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (res_status_r == gha_pkg::ST_OK))
    else $error("index reuse without ok status");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_req.ready)
    else $error("request taken while sequencer busy");

endmodule : generational_handle_allocator
`default_nettype wire
